// ===== rtl/core/rba_pkg.sv =====
// Package for the rectangle blit and alpha blend unit.
// Holds image size defaults, field widths, request and register codes, config struct.
// No dependencies.
package rba_pkg;

  localparam int unsigned IMG_WIDTH_DEF       = 256;
  localparam int unsigned IMG_HEIGHT_DEF      = 256;
  localparam int unsigned BYTES_PER_PIXEL_DEF = 4;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 18;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned ROW_W   = SIZE_W;
  localparam int unsigned COL_W   = SIZE_W + 2;
  localparam int unsigned FIT_W   = 13;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CDATA_W = SIZE_W;
  localparam int unsigned PROD_W  = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] ALPHA_MAX   = 8'd255;
  localparam logic [BYTE_W-1:0] ALPHA_RESET = 8'd255;

  localparam logic [OP_W-1:0] OP_WR_SRC = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_DST = 2'd1;
  localparam logic [OP_W-1:0] OP_BLIT   = 2'd2;
  localparam logic [OP_W-1:0] OP_RD_DST = 2'd3;

  localparam logic [IDX_W-1:0] REG_SRC_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_RECT_W   = 3'd2;
  localparam logic [IDX_W-1:0] REG_RECT_H   = 3'd3;
  localparam logic [IDX_W-1:0] REG_DST_X    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DST_Y    = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLEND_ON = 3'd6;
  localparam logic [IDX_W-1:0] REG_ALPHA    = 3'd7;

  typedef struct packed {
    logic [POS_W-1:0]  src_x;
    logic [POS_W-1:0]  src_y;
    logic [SIZE_W-1:0] rect_w;
    logic [SIZE_W-1:0] rect_h;
    logic [POS_W-1:0]  dst_x;
    logic [POS_W-1:0]  dst_y;
    logic              blend_on;
    logic [BYTE_W-1:0] alpha;
  } cfg_t;

endpackage

// ===== rtl/core/rba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rba_cfg.sv =====
// Configuration register file for the blit unit.
// Depends on rba_pkg for register codes and the cfg_t struct.
module rba_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [rba_pkg::IDX_W-1:0]    index,
  input  logic [rba_pkg::CDATA_W-1:0]  data,
  output rba_pkg::cfg_t                cfg
);

  rba_pkg::cfg_t cfg_r;
  rba_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (index)
        rba_pkg::REG_SRC_X:    cfg_nxt.src_x    = data[rba_pkg::POS_W-1:0];
        rba_pkg::REG_SRC_Y:    cfg_nxt.src_y    = data[rba_pkg::POS_W-1:0];
        rba_pkg::REG_RECT_W:   cfg_nxt.rect_w   = data[rba_pkg::SIZE_W-1:0];
        rba_pkg::REG_RECT_H:   cfg_nxt.rect_h   = data[rba_pkg::SIZE_W-1:0];
        rba_pkg::REG_DST_X:    cfg_nxt.dst_x    = data[rba_pkg::POS_W-1:0];
        rba_pkg::REG_DST_Y:    cfg_nxt.dst_y    = data[rba_pkg::POS_W-1:0];
        rba_pkg::REG_BLEND_ON: cfg_nxt.blend_on = data[0];
        rba_pkg::REG_ALPHA:    cfg_nxt.alpha    = data[rba_pkg::BYTE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_x    <= '0;
      cfg_r.src_y    <= '0;
      cfg_r.rect_w   <= '0;
      cfg_r.rect_h   <= '0;
      cfg_r.dst_x    <= '0;
      cfg_r.dst_y    <= '0;
      cfg_r.blend_on <= 1'b0;
      cfg_r.alpha    <= rba_pkg::ALPHA_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/rba_blend.sv =====
// Shared blend unit: registered products s*alpha and d*(255-alpha), then sum >> 8;
// registered src if blend_on is low. Depends on rba_pkg for widths, alpha ceiling.
module rba_blend (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        blend_on,
  input  logic [rba_pkg::BYTE_W-1:0]  alpha,
  input  logic [rba_pkg::BYTE_W-1:0]  src,
  input  logic [rba_pkg::BYTE_W-1:0]  dst,
  output logic [rba_pkg::BYTE_W-1:0]  result
);

  logic [rba_pkg::PROD_W-1:0] prod_s_r;
  logic [rba_pkg::PROD_W-1:0] prod_d_r;
  logic [rba_pkg::BYTE_W-1:0] src_r;
  logic [rba_pkg::PROD_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_s_r <= rba_pkg::PROD_W'(src) * rba_pkg::PROD_W'(alpha);
      prod_d_r <= rba_pkg::PROD_W'(dst) * rba_pkg::PROD_W'(rba_pkg::ALPHA_MAX - alpha);
      src_r    <= src;
    end
  end

  assign sum    = prod_s_r + prod_d_r;
  assign result = blend_on ? sum[rba_pkg::PROD_W-1:rba_pkg::BYTE_W] : src_r;

endmodule

// ===== rtl/core/rect_blit_alpha_blend_unit.sv =====
// Top level of the rectangle blit and alpha blend unit: sequencer, image RAMs.
// Depends on rba_pkg, rba_ram, rba_cfg and rba_blend.
//
// Channel   Handshake              Payload
// input     start & !busy          in_op, in_addr, in_data
// result    out_valid (strobe)     out_read_data, out_status
// config    cfg_valid & cfg_ready  cfg_index, cfg_data
//
// A write request (source or destination) is answered from ST_CMD; a destination read
// passes through ST_RDATA as well. A blit takes each byte through read, multiply and
// write-back in the one blend unit and one dest RAM port; a rejected or empty blit
// is answered from ST_CMD. busy is high from acceptance to the strobe.
// Synchronous active-low reset; image RAMs need no clearing. Results cannot be stalled.
module rect_blit_alpha_blend_unit #(
  parameter int unsigned IMG_WIDTH       = rba_pkg::IMG_WIDTH_DEF,
  parameter int unsigned IMG_HEIGHT      = rba_pkg::IMG_HEIGHT_DEF,
  parameter int unsigned BYTES_PER_PIXEL = rba_pkg::BYTES_PER_PIXEL_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rba_pkg::OP_W-1:0]      in_op,
  input  logic [rba_pkg::ADDR_W-1:0]    in_addr,
  input  logic [rba_pkg::BYTE_W-1:0]    in_data,
  output logic                          out_valid,
  output logic [rba_pkg::BYTE_W-1:0]    out_read_data,
  output logic                          out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rba_pkg::IDX_W-1:0]     cfg_index,
  input  logic [rba_pkg::CDATA_W-1:0]   cfg_data
);

  localparam int unsigned IMG_BYTES  = IMG_WIDTH * IMG_HEIGHT * BYTES_PER_PIXEL;
  localparam int unsigned AW         = (IMG_BYTES > 1) ? $clog2(IMG_BYTES) : 1;
  localparam int unsigned ROW_STRIDE = IMG_WIDTH * BYTES_PER_PIXEL;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMD   = 3'd1;
  localparam logic [2:0] ST_RDATA = 3'd2;
  localparam logic [2:0] ST_BRD   = 3'd3;
  localparam logic [2:0] ST_BMUL  = 3'd4;
  localparam logic [2:0] ST_BWR   = 3'd5;

  rba_pkg::cfg_t cfg;

  logic [2:0]                   state_r, state_nxt;
  logic [rba_pkg::OP_W-1:0]     op_r;
  logic [rba_pkg::ADDR_W-1:0]   addr_r;
  logic [rba_pkg::BYTE_W-1:0]   data_r;
  logic [AW-1:0]                s_base_r, s_base_nxt;
  logic [AW-1:0]                d_base_r, d_base_nxt;
  logic [AW-1:0]                di_r, di_nxt;
  logic [rba_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [rba_pkg::COL_W-1:0]    col_end_r, col_end_nxt;
  logic [rba_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rba_pkg::BYTE_W-1:0]   out_read_data_r, out_read_data_nxt;
  logic                         out_status_r, out_status_nxt;

  logic                         accept;
  logic                         addr_in_range;
  logic                         src_fits;
  logic                         dst_fits;
  logic                         last_col;
  logic                         last_row;
  logic [AW-1:0]                s_addr;
  logic [AW-1:0]                d_addr;
  logic                         src_we;
  logic                         dst_we;
  logic [AW-1:0]                dst_waddr;
  logic [rba_pkg::BYTE_W-1:0]   dst_wdata;
  logic [AW-1:0]                dst_raddr;
  logic [rba_pkg::BYTE_W-1:0]   src_rdata;
  logic [rba_pkg::BYTE_W-1:0]   dst_rdata;
  logic                         blend_load;
  logic [rba_pkg::BYTE_W-1:0]   blend_result;

  assign accept        = start && !busy;
  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign addr_in_range = (32'(addr_r) < IMG_BYTES);

  assign src_fits =
    (rba_pkg::FIT_W'(cfg.src_x) + rba_pkg::FIT_W'(cfg.rect_w) <= rba_pkg::FIT_W'(IMG_WIDTH)) &&
    (rba_pkg::FIT_W'(cfg.src_y) + rba_pkg::FIT_W'(cfg.rect_h) <= rba_pkg::FIT_W'(IMG_HEIGHT));
  assign dst_fits =
    (rba_pkg::FIT_W'(cfg.dst_x) + rba_pkg::FIT_W'(cfg.rect_w) <= rba_pkg::FIT_W'(IMG_WIDTH)) &&
    (rba_pkg::FIT_W'(cfg.dst_y) + rba_pkg::FIT_W'(cfg.rect_h) <= rba_pkg::FIT_W'(IMG_HEIGHT));

  assign s_addr   = s_base_r + AW'(col_r);
  assign d_addr   = d_base_r + AW'(col_r);
  assign last_col = (col_r == col_end_r - rba_pkg::COL_W'(1));
  assign last_row = (row_r == cfg.rect_h - rba_pkg::ROW_W'(1));

  rba_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  rba_ram #(
    .WIDTH (rba_pkg::BYTE_W),
    .DEPTH (IMG_BYTES)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (AW'(addr_r)),
    .wdata (data_r),
    .raddr (s_addr),
    .rdata (src_rdata)
  );

  rba_ram #(
    .WIDTH (rba_pkg::BYTE_W),
    .DEPTH (IMG_BYTES)
  ) u_dst_ram (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_waddr),
    .wdata (dst_wdata),
    .raddr (dst_raddr),
    .rdata (dst_rdata)
  );

  rba_blend u_blend (
    .clk      (clk),
    .load     (blend_load),
    .blend_on (cfg.blend_on),
    .alpha    (cfg.alpha),
    .src      (src_rdata),
    .dst      (dst_rdata),
    .result   (blend_result)
  );

  always_comb begin
    state_nxt         = state_r;
    s_base_nxt        = s_base_r;
    d_base_nxt        = d_base_r;
    di_nxt            = di_r;
    col_nxt           = col_r;
    col_end_nxt       = col_end_r;
    row_nxt           = row_r;
    out_valid_nxt     = 1'b0;
    out_read_data_nxt = out_read_data_r;
    out_status_nxt    = out_status_r;
    src_we            = 1'b0;
    dst_we            = 1'b0;
    dst_waddr         = AW'(addr_r);
    dst_wdata         = data_r;
    dst_raddr         = d_addr;
    blend_load        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        unique case (op_r)
          rba_pkg::OP_WR_SRC: begin
            src_we            = addr_in_range;
            out_valid_nxt     = 1'b1;
            out_read_data_nxt = '0;
            out_status_nxt    = 1'b0;
            state_nxt         = ST_IDLE;
          end
          rba_pkg::OP_WR_DST: begin
            dst_we            = addr_in_range;
            out_valid_nxt     = 1'b1;
            out_read_data_nxt = '0;
            out_status_nxt    = 1'b0;
            state_nxt         = ST_IDLE;
          end
          rba_pkg::OP_RD_DST: begin
            dst_raddr = AW'(addr_r);
            state_nxt = ST_RDATA;
          end
          rba_pkg::OP_BLIT: begin
            out_read_data_nxt = '0;
            if (!(src_fits && dst_fits)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = 1'b1;
              state_nxt      = ST_IDLE;
            end else if (cfg.rect_w == '0 || cfg.rect_h == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = 1'b0;
              state_nxt      = ST_IDLE;
            end else begin
              s_base_nxt  = AW'((32'(cfg.src_y) * IMG_WIDTH + 32'(cfg.src_x)) * BYTES_PER_PIXEL);
              d_base_nxt  = AW'((32'(cfg.dst_y) * IMG_WIDTH + 32'(cfg.dst_x)) * BYTES_PER_PIXEL);
              col_end_nxt = rba_pkg::COL_W'(32'(cfg.rect_w) * BYTES_PER_PIXEL);
              col_nxt     = '0;
              row_nxt     = '0;
              state_nxt   = ST_BRD;
            end
          end
        endcase
      end
      ST_RDATA: begin
        out_valid_nxt     = 1'b1;
        out_read_data_nxt = addr_in_range ? dst_rdata : '0;
        out_status_nxt    = 1'b0;
        state_nxt         = ST_IDLE;
      end
      ST_BRD: begin
        di_nxt    = d_addr;
        state_nxt = ST_BMUL;
      end
      ST_BMUL: begin
        blend_load = 1'b1;
        state_nxt  = ST_BWR;
      end
      ST_BWR: begin
        dst_we    = 1'b1;
        dst_waddr = di_r;
        dst_wdata = blend_result;
        if (last_col) begin
          col_nxt    = '0;
          row_nxt    = row_r + rba_pkg::ROW_W'(1);
          s_base_nxt = s_base_r + AW'(ROW_STRIDE);
          d_base_nxt = d_base_r + AW'(ROW_STRIDE);
          if (last_row) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_BRD;
          end
        end else begin
          col_nxt   = col_r + rba_pkg::COL_W'(1);
          state_nxt = ST_BRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      addr_r <= in_addr;
      data_r <= in_data;
    end
    s_base_r        <= s_base_nxt;
    d_base_r        <= d_base_nxt;
    di_r            <= di_nxt;
    col_r           <= col_nxt;
    col_end_r       <= col_end_nxt;
    row_r           <= row_nxt;
    out_read_data_r <= out_read_data_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

`ifndef ASSERT_OFF
  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BWR) |-> (dst_waddr == $past(d_addr, 2)))
    else $error("blit write-back address differs from read address");

  a_reject_only_blit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (op_r == rba_pkg::OP_BLIT && out_read_data == '0))
    else $error("reject status on a non-blit request");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BRD) |-> (col_r < col_end_r && row_r < cfg.rect_h))
    else $error("blit walk outside the rectangle");
`endif

endmodule

// ===== bench/tb_rect_blit_alpha_blend_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rect_blit_alpha_blend_unit: byte loads, reads and blits are
// checked against a byte-exact mirror of both images held in a scoreboard class.
// Depends on rba_pkg and the RTL of the unit.
module tb_rect_blit_alpha_blend_unit;

  localparam int unsigned IMG_W       = rba_pkg::IMG_WIDTH_DEF;
  localparam int unsigned IMG_H       = rba_pkg::IMG_HEIGHT_DEF;
  localparam int unsigned BPP         = rba_pkg::BYTES_PER_PIXEL_DEF;
  localparam int unsigned IMG_BYTES   = IMG_W * IMG_H * BPP;
  localparam int unsigned ADDR_TOP    = (1 << rba_pkg::ADDR_W) - 1;
  localparam int unsigned EDGE_W      = IMG_W / 8;
  localparam int unsigned EDGE_H      = IMG_H / 8;
  localparam int unsigned RAND_ITEMS  = 700;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_GAP     = 6;

  typedef struct packed {
    logic [rba_pkg::BYTE_W-1:0] read_data;
    logic                       status;
  } reply_t;

  class blit_mirror;
    bit [rba_pkg::BYTE_W-1:0] src_img [IMG_BYTES];
    bit                       src_set [IMG_BYTES];
    bit [rba_pkg::BYTE_W-1:0] dst_img [IMG_BYTES];
    bit                       dst_set [IMG_BYTES];
    int unsigned              dst_seen [$];
    rba_pkg::cfg_t            regs;
    reply_t                   expected_replies [$];
    int unsigned              errors;

    function new();
      regs = '0;
      regs.alpha = rba_pkg::ALPHA_RESET;
      errors = 0;
    endfunction

    function void note_config(logic [rba_pkg::IDX_W-1:0] idx,
                              logic [rba_pkg::CDATA_W-1:0] value);
      case (idx)
        rba_pkg::REG_SRC_X:    regs.src_x = value[rba_pkg::POS_W-1:0];
        rba_pkg::REG_SRC_Y:    regs.src_y = value[rba_pkg::POS_W-1:0];
        rba_pkg::REG_RECT_W:   regs.rect_w = value[rba_pkg::SIZE_W-1:0];
        rba_pkg::REG_RECT_H:   regs.rect_h = value[rba_pkg::SIZE_W-1:0];
        rba_pkg::REG_DST_X:    regs.dst_x = value[rba_pkg::POS_W-1:0];
        rba_pkg::REG_DST_Y:    regs.dst_y = value[rba_pkg::POS_W-1:0];
        rba_pkg::REG_BLEND_ON: regs.blend_on = value[0];
        rba_pkg::REG_ALPHA:    regs.alpha = value[rba_pkg::BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function bit apply_blit();
      int unsigned w, h, sx, sy, dx, dy, a, s, d, si, di, row, col;
      w = 32'(regs.rect_w);
      h = 32'(regs.rect_h);
      sx = 32'(regs.src_x);
      sy = 32'(regs.src_y);
      dx = 32'(regs.dst_x);
      dy = 32'(regs.dst_y);
      a = 32'(regs.alpha);
      if (sx + w > IMG_W || sy + h > IMG_H || dx + w > IMG_W || dy + h > IMG_H) begin
        return 1'b1;
      end
      for (row = 0; row < h; row++) begin
        for (col = 0; col < w * BPP; col++) begin
          si = ((sy + row) * IMG_W + sx) * BPP + col;
          di = ((dy + row) * IMG_W + dx) * BPP + col;
          if (si < IMG_BYTES && di < IMG_BYTES) begin
            s = 32'(src_img[si]);
            d = 32'(dst_img[di]);
            if (regs.blend_on) begin
              dst_img[di] = rba_pkg::BYTE_W'((s * a + d * (32'(rba_pkg::ALPHA_MAX) - a))
                                             >> rba_pkg::BYTE_W);
            end else begin
              dst_img[di] = rba_pkg::BYTE_W'(s);
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [rba_pkg::OP_W-1:0] op,
                               logic [rba_pkg::ADDR_W-1:0] addr,
                               logic [rba_pkg::BYTE_W-1:0] data);
      reply_t r;
      r = '0;
      case (op)
        rba_pkg::OP_WR_SRC: begin
          if (addr < IMG_BYTES) begin
            src_img[addr] = data;
            src_set[addr] = 1'b1;
          end
        end
        rba_pkg::OP_WR_DST: begin
          if (addr < IMG_BYTES) begin
            if (!dst_set[addr]) dst_seen.push_back(32'(addr));
            dst_img[addr] = data;
            dst_set[addr] = 1'b1;
          end
        end
        rba_pkg::OP_BLIT: r.status = apply_blit();
        default: begin
          if (addr < IMG_BYTES) r.read_data = dst_img[addr];
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [rba_pkg::BYTE_W-1:0] rd, logic st);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result rd=%0d st=%0d with no request pending", rd, st));
      end else begin
        want = expected_replies.pop_front();
        if (rd !== want.read_data) begin
          report_mismatch($sformatf("read_data %0d, expected %0d", rd, want.read_data));
        end
        if (st !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
        end
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [rba_pkg::OP_W-1:0]    in_op = '0;
  logic [rba_pkg::ADDR_W-1:0]  in_addr = '0;
  logic [rba_pkg::BYTE_W-1:0]  in_data = '0;
  logic                        out_valid;
  logic [rba_pkg::BYTE_W-1:0]  out_read_data;
  logic                        out_status;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [rba_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [rba_pkg::CDATA_W-1:0] cfg_data = '0;

  blit_mirror  mirror;
  int unsigned gap_pct = 0;
  int unsigned sent_items = 0;
  int unsigned cycle_count = 0;

  rect_blit_alpha_blend_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_addr       (in_addr),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) mirror.check_result(out_read_data, out_status);
  end

  task automatic send_request(input logic [rba_pkg::OP_W-1:0] op,
                              input logic [rba_pkg::ADDR_W-1:0] addr,
                              input logic [rba_pkg::BYTE_W-1:0] data);
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
    end
    start = 1'b1;
    in_op = op;
    in_addr = addr;
    in_data = data;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.note_request(op, addr, data);
    sent_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (mirror.expected_replies.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic set_reg(input logic [rba_pkg::IDX_W-1:0] idx,
                         input logic [rba_pkg::CDATA_W-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror.note_config(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [rba_pkg::CDATA_W-1:0] spare_high(input int unsigned v);
    logic [rba_pkg::CDATA_W-1:0] r;
    r = rba_pkg::CDATA_W'(v);
    r[rba_pkg::CDATA_W-1] = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic int unsigned pick_alpha();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 32'(rba_pkg::ALPHA_MAX);
      default: return $urandom_range(0, 32'(rba_pkg::ALPHA_MAX));
    endcase
  endfunction

  function automatic logic [rba_pkg::BYTE_W-1:0] rand_byte();
    return rba_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [rba_pkg::ADDR_W-1:0] rand_addr();
    return rba_pkg::ADDR_W'($urandom_range(0, ADDR_TOP));
  endfunction

  task automatic place_rect(input int unsigned sx, sy, w, h, dx, dy,
                            input bit blend, input int unsigned alpha);
    logic [rba_pkg::CDATA_W-1:0] bw;
    bw = rba_pkg::CDATA_W'($urandom_range(0, (1 << rba_pkg::CDATA_W) - 1));
    bw[0] = blend;
    set_reg(rba_pkg::REG_SRC_X, spare_high(sx));
    set_reg(rba_pkg::REG_SRC_Y, spare_high(sy));
    set_reg(rba_pkg::REG_RECT_W, rba_pkg::CDATA_W'(w));
    set_reg(rba_pkg::REG_RECT_H, rba_pkg::CDATA_W'(h));
    set_reg(rba_pkg::REG_DST_X, spare_high(dx));
    set_reg(rba_pkg::REG_DST_Y, spare_high(dy));
    set_reg(rba_pkg::REG_BLEND_ON, bw);
    set_reg(rba_pkg::REG_ALPHA, spare_high(alpha));
  endtask

  // load every byte of the rectangle not yet written, and rewrite some of the rest
  task automatic fill_rect(input bit to_dst, input int unsigned x, y, w, h);
    int unsigned row, col, a;
    bit known;
    for (row = 0; row < h; row++) begin
      for (col = 0; col < w * BPP; col++) begin
        a = ((y + row) * IMG_W + x) * BPP + col;
        known = to_dst ? mirror.dst_set[a] : mirror.src_set[a];
        if (!known || $urandom_range(0, 3) == 0) begin
          send_request(to_dst ? rba_pkg::OP_WR_DST : rba_pkg::OP_WR_SRC,
                       rba_pkg::ADDR_W'(a), rand_byte());
        end
      end
    end
  endtask

  task automatic read_back(input int unsigned x, y, w, h, n);
    int unsigned a;
    repeat (n) begin
      a = ((y + $urandom_range(0, h - 1)) * IMG_W + x) * BPP + $urandom_range(0, w * BPP - 1);
      send_request(rba_pkg::OP_RD_DST, rba_pkg::ADDR_W'(a), rand_byte());
    end
  endtask

  task automatic send_blit();
    send_request(rba_pkg::OP_BLIT, rand_addr(), rand_byte());
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: send_request(rba_pkg::OP_WR_SRC, rand_addr(), rand_byte());
        1: send_request(rba_pkg::OP_WR_DST, rand_addr(), rand_byte());
        default: send_request(rba_pkg::OP_RD_DST,
                              rba_pkg::ADDR_W'(mirror.dst_seen[
                                $urandom_range(0, mirror.dst_seen.size() - 1)]),
                              rand_byte());
      endcase
    end
  endtask

  task automatic random_sequence();
    int unsigned kind, w, h, sx, sy, dx, dy;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      w = $urandom_range(1, 3);
      h = $urandom_range(1, 3);
      sx = $urandom_range(0, IMG_W - w);
      sy = $urandom_range(0, IMG_H - h);
      dx = $urandom_range(0, IMG_W - w);
      dy = $urandom_range(0, IMG_H - h);
      place_rect(sx, sy, w, h, dx, dy, 1'($urandom_range(0, 1)), pick_alpha());
      fill_rect(1'b0, sx, sy, w, h);
      send_noise($urandom_range(0, 3));
      fill_rect(1'b1, dx, dy, w, h);
      send_blit();
      if ($urandom_range(0, 2) == 0) send_blit();
      read_back(dx, dy, w, h, $urandom_range(1, w * h * BPP));
    end else if (kind < 9) begin
      do begin
        w = $urandom_range(0, (1 << rba_pkg::SIZE_W) - 1);
        h = $urandom_range(0, (1 << rba_pkg::SIZE_W) - 1);
        sx = $urandom_range(0, IMG_W - 1);
        sy = $urandom_range(0, IMG_H - 1);
        dx = $urandom_range(0, IMG_W - 1);
        dy = $urandom_range(0, IMG_H - 1);
      end while (sx + w <= IMG_W && sy + h <= IMG_H && dx + w <= IMG_W && dy + h <= IMG_H);
      place_rect(sx, sy, w, h, dx, dy, 1'($urandom_range(0, 1)), pick_alpha());
      send_noise($urandom_range(0, 2));
      send_blit();
      send_noise($urandom_range(1, 4));
    end else begin
      w = $urandom_range(0, 1) ? 0 : $urandom_range(0, IMG_W);
      h = (w == 0) ? $urandom_range(0, IMG_H) : 0;
      place_rect($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1), w, h,
                 $urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1),
                 1'($urandom_range(0, 1)), pick_alpha());
      send_blit();
      send_noise($urandom_range(1, 4));
    end
  endtask

  initial begin
    int unsigned base;
    mirror = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_pct = 12;
    send_blit();
    send_request(rba_pkg::OP_WR_SRC, '0, 8'hFF);
    send_request(rba_pkg::OP_WR_DST, '0, 8'h00);
    send_request(rba_pkg::OP_WR_SRC, rba_pkg::ADDR_W'(ADDR_TOP), 8'hA5);
    send_request(rba_pkg::OP_WR_DST, rba_pkg::ADDR_W'(ADDR_TOP), 8'h5A);
    send_request(rba_pkg::OP_RD_DST, rba_pkg::ADDR_W'(ADDR_TOP), 8'hFF);
    send_request(rba_pkg::OP_RD_DST, '0, 8'h00);

    place_rect(IMG_W - 1, IMG_H - 1, 1, 1, 0, 0, 1'b0, 32'(rba_pkg::ALPHA_MAX));
    fill_rect(1'b0, IMG_W - 1, IMG_H - 1, 1, 1);
    fill_rect(1'b1, 0, 0, 1, 1);
    send_blit();
    read_back(0, 0, 1, 1, 2);

    place_rect(0, 0, 1, 1, IMG_W - 1, IMG_H - 1, 1'b1, 0);
    fill_rect(1'b0, 0, 0, 1, 1);
    fill_rect(1'b1, IMG_W - 1, IMG_H - 1, 1, 1);
    send_blit();
    set_reg(rba_pkg::REG_ALPHA, rba_pkg::CDATA_W'(rba_pkg::ALPHA_MAX));
    send_blit();
    read_back(IMG_W - 1, IMG_H - 1, 1, 1, 2);

    place_rect(1, 0, IMG_W, 1, 0, 0, 1'b0, 0);
    send_blit();
    place_rect(0, 0, 1, (1 << rba_pkg::SIZE_W) - 1, 0, 0, 1'b1, 0);
    send_blit();
    place_rect(0, 0, 1, 2, 0, IMG_H - 1, 1'b1, 32'(rba_pkg::ALPHA_MAX));
    send_blit();
    place_rect(0, 0, IMG_W, 0, 0, 0, 1'b1, 32'(rba_pkg::ALPHA_MAX));
    send_blit();

    // wide row at the right edge and tall column at the bottom edge
    place_rect(IMG_W - EDGE_W, 0, EDGE_W, 1, 0, IMG_H - 1, 1'b1, pick_alpha());
    fill_rect(1'b0, IMG_W - EDGE_W, 0, EDGE_W, 1);
    fill_rect(1'b1, 0, IMG_H - 1, EDGE_W, 1);
    send_blit();
    read_back(0, IMG_H - 1, EDGE_W, 1, 8);
    place_rect(IMG_W - 1, IMG_H - EDGE_H, 1, EDGE_H, 0, 0, 1'b0, pick_alpha());
    fill_rect(1'b0, IMG_W - 1, IMG_H - EDGE_H, 1, EDGE_H);
    fill_rect(1'b1, 0, 0, 1, EDGE_H);
    send_blit();
    read_back(0, 0, 1, EDGE_H, 8);

    base = sent_items;
    while (sent_items - base < RAND_ITEMS) begin
      if (sent_items - base < RAND_ITEMS / 3) begin
        gap_pct = 12;
      end else if (sent_items - base < 2 * RAND_ITEMS / 3) begin
        gap_pct = 87;
      end else begin
        gap_pct = 0;
      end
      random_sequence();
    end

    drain();
    repeat (16) @(posedge clk);
    if (mirror.errors == 0 && mirror.expected_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
